// File: hdl/tlik_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared constants and types of the two-link leg inverse kinematics block.
// ----------------------------------------------------------------------------
package tlik_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
   localparam int CORDIC_LATENCY    = CORDIC_STEPS + 3;
   localparam int SQRT_STEPS        = 32;

   localparam logic signed [31:0] ANGLE_PI = 32'sd52707179;

   // atan(2^-i) in 2^-24 rad
   localparam logic [23:0] ATAN_TABLE [32] = '{
      24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
      24'd1047214,  24'd524117,  24'd262123,  24'd131069,
      24'd65536,    24'd32768,   24'd16384,   24'd8192,
      24'd4096,     24'd2048,    24'd1024,    24'd512,
      24'd256,      24'd128,     24'd64,      24'd32,
      24'd16,       24'd8,       24'd4,       24'd2,
      24'd1,        24'd0,       24'd0,       24'd0,
      24'd0,        24'd0,       24'd0,       24'd0
   };

   typedef enum logic [0:0] {
      CSR_UPPER_LINK = 1'b0,
      CSR_LOWER_LINK = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic        xneg;
      logic        yneg;
      logic [31:0] xmag;
      logic [31:0] ymag;
   } cordic_in_type;

   typedef struct packed {
      logic        xneg;
      logic        zneg;
      logic [15:0] xmag;
      logic [15:0] zmag;
      logic        nneg;
      logic [31:0] nmag;
      logic        reach;
   } side_type;

endpackage
`default_nettype wire

// File: hdl/tlik_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_if
// Valid/ready channels for foot targets and joint angle results.
// ----------------------------------------------------------------------------
interface tlik_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] x_pos;
   logic signed [15:0] z_pos;
   modport source (output valid, output x_pos, output z_pos, input ready);
   modport sink (input valid, input x_pos, input z_pos, output ready);
endinterface

interface tlik_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] first_angle;
   logic signed [15:0] second_angle;
   logic               reachable;
   modport source (output valid, output first_angle, output second_angle,
                   output reachable, input ready);
   modport sink (input valid, input first_angle, input second_angle,
                 input reachable, output ready);
endinterface
`default_nettype wire

// File: hdl/tlik_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_cordic
// Pipelined vectoring CORDIC atan2, one stage per iteration, 2^-24 rad out.
// ----------------------------------------------------------------------------
module tlik_cordic
   import tlik_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          en,
   input  wire cordic_in_type vec,
   output logic signed [31:0] angle
);

   logic [4:0]    msb_in;
   cordic_in_type a_vec_ff;
   logic [4:0]    a_msb_ff;
   logic          a_zero_ff;
   logic [31:0]   xn_in;
   logic [31:0]   yn_in;

   // flags: {zero, xneg, yneg}
   logic [2:0]         fl_ff  [CORDIC_STEPS+1];
   logic signed [34:0] cx_ff  [CORDIC_STEPS+1];
   logic signed [34:0] cy_ff  [CORDIC_STEPS+1];
   logic signed [31:0] acc_ff [CORDIC_STEPS+1];
   logic signed [34:0] cx_in  [CORDIC_STEPS];
   logic signed [34:0] cy_in  [CORDIC_STEPS];
   logic signed [31:0] acc_in [CORDIC_STEPS];
   logic signed [31:0] fin_in;
   logic signed [31:0] angle_ff;

   always_comb begin
      logic [31:0] m;
      m = vec.xmag | vec.ymag;
      msb_in = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (m[i]) begin
            msb_in = 5'(i);
         end
      end
   end

   always_comb begin
      if (a_msb_ff == 5'd31) begin
         xn_in = {1'b0, a_vec_ff.xmag[31:1]};
         yn_in = {1'b0, a_vec_ff.ymag[31:1]};
      end else begin
         xn_in = a_vec_ff.xmag << (5'd30 - a_msb_ff);
         yn_in = a_vec_ff.ymag << (5'd30 - a_msb_ff);
      end
   end

   always_comb begin
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         logic signed [34:0] dx;
         logic signed [34:0] dy;
         logic signed [31:0] tab;
         dx  = cy_ff[k] >>> k;
         dy  = cx_ff[k] >>> k;
         tab = signed'({8'b0, ATAN_TABLE[k]});
         if (!cy_ff[k][34]) begin
            cx_in[k]  = cx_ff[k] + dx;
            cy_in[k]  = cy_ff[k] - dy;
            acc_in[k] = acc_ff[k] + tab;
         end else begin
            cx_in[k]  = cx_ff[k] - dx;
            cy_in[k]  = cy_ff[k] + dy;
            acc_in[k] = acc_ff[k] - tab;
         end
      end
   end

   always_comb begin
      logic signed [31:0] t;
      t = fl_ff[CORDIC_STEPS][1] ? ANGLE_PI - acc_ff[CORDIC_STEPS] : acc_ff[CORDIC_STEPS];
      if (fl_ff[CORDIC_STEPS][0]) begin
         t = -t;
      end
      fin_in = fl_ff[CORDIC_STEPS][2] ? 32'sd0 : t;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_vec_ff  <= vec;
         a_msb_ff  <= msb_in;
         a_zero_ff <= ((vec.xmag | vec.ymag) == 32'd0);
         fl_ff[0]  <= {a_zero_ff, a_vec_ff.xneg, a_vec_ff.yneg};
         cx_ff[0]  <= signed'({3'b0, xn_in});
         cy_ff[0]  <= signed'({3'b0, yn_in});
         acc_ff[0] <= 32'sd0;
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            fl_ff[k+1]  <= fl_ff[k];
            cx_ff[k+1]  <= cx_in[k];
            cy_ff[k+1]  <= cy_in[k];
            acc_ff[k+1] <= acc_in[k];
         end
         angle_ff <= fin_in;
      end
   end

   assign angle = angle_ff;

endmodule
`default_nettype wire

// File: hdl/two_link_leg_inverse_kinematics.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_link_leg_inverse_kinematics
// Law-of-cosines joint angle solver for a two-link leg.
// ----------------------------------------------------------------------------
// Fully pipelined: one target is accepted every cycle while the result side is
// not stalled. The pipeline depth is set by the 32-stage square root and the
// per-iteration CORDIC stages; a stall on the result side freezes the whole
// pipeline. Link lengths may be written only while the pipeline is empty.
module two_link_leg_inverse_kinematics
   import tlik_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   tlik_req_if.sink         req_chan,
   tlik_rsp_if.source       rsp_chan,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [14:0] csr_write_data
);

   localparam int NSTAGES = 38 + CORDIC_LATENCY;

   logic [14:0] upper_ff;
   logic [14:0] lower_ff;
   logic [NSTAGES-1:0] vld_ff;
   logic en;

   assign en = !vld_ff[NSTAGES-1] || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= 15'd7340;
         lower_ff <= 15'd2949;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_UPPER_LINK: upper_ff <= csr_write_data;
            CSR_LOWER_LINK: lower_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTAGES-2:0], req_chan.valid};
      end
   end

   // stage 1
   logic signed [15:0] s1_x_ff, s1_z_ff;
   logic [30:0] s1_xsq_ff, s1_zsq_ff;
   logic [29:0] s1_asq_ff, s1_bsq_ff, s1_dsq_ff;
   logic [31:0] s1_ssq_ff;
   logic [14:0] dab_in;
   logic [15:0] sab_in;
   logic signed [31:0] xsq_in, zsq_in;

   assign dab_in = (upper_ff > lower_ff) ? upper_ff - lower_ff : lower_ff - upper_ff;
   assign sab_in = {1'b0, upper_ff} + {1'b0, lower_ff};
   assign xsq_in = req_chan.x_pos * req_chan.x_pos;
   assign zsq_in = req_chan.z_pos * req_chan.z_pos;

   // stage 2
   logic signed [15:0] s2_x_ff, s2_z_ff;
   logic [31:0] s2_r2_ff, s2_ssq_ff;
   logic [29:0] s2_asq_ff, s2_bsq_ff, s2_dsq_ff;

   // stage 3
   logic [31:0] s3_r2_ff;
   logic [29:0] s3_bsq_ff;
   side_type    s3_side_ff;
   side_type    s3_side_in;
   logic signed [33:0] num_in;

   always_comb begin
      num_in = signed'({4'b0, s2_bsq_ff}) + signed'({2'b0, s2_r2_ff})
             - signed'({4'b0, s2_asq_ff});
      s3_side_in.xneg  = s2_x_ff[15];
      s3_side_in.zneg  = s2_z_ff[15];
      s3_side_in.xmag  = s2_x_ff[15] ? 16'(-s2_x_ff) : s2_x_ff;
      s3_side_in.zmag  = s2_z_ff[15] ? 16'(-s2_z_ff) : s2_z_ff;
      s3_side_in.nneg  = num_in[33];
      s3_side_in.nmag  = num_in[33] ? 32'(-num_in) : num_in[31:0];
      s3_side_in.reach = !({2'b0, s2_dsq_ff} >= s2_r2_ff || s2_r2_ff >= s2_ssq_ff);
   end

   // stage 4
   logic [63:0] s4_prod_ff, s4_nsq_ff;
   side_type    s4_side_ff;
   logic [61:0] prod_in;

   assign prod_in = s3_bsq_ff * s3_r2_ff;

   // square root stages
   logic [63:0] sq_v_ff [SQRT_STEPS+1];
   logic [63:0] sq_r_ff [SQRT_STEPS+1];
   side_type    side_ff [SQRT_STEPS+1];
   logic [63:0] sq_v_in [SQRT_STEPS];
   logic [63:0] sq_r_in [SQRT_STEPS];

   always_comb begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
         logic [63:0] bit_k;
         logic [63:0] t;
         bit_k = 64'd1 << (62 - 2 * k);
         t = sq_r_ff[k] + bit_k;
         if (sq_v_ff[k] >= t) begin
            sq_v_in[k] = sq_v_ff[k] - t;
            sq_r_in[k] = (sq_r_ff[k] >> 1) + bit_k;
         end else begin
            sq_v_in[k] = sq_v_ff[k];
            sq_r_in[k] = sq_r_ff[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff   <= req_chan.x_pos;
         s1_z_ff   <= req_chan.z_pos;
         s1_xsq_ff <= xsq_in[30:0];
         s1_zsq_ff <= zsq_in[30:0];
         s1_asq_ff <= upper_ff * upper_ff;
         s1_bsq_ff <= lower_ff * lower_ff;
         s1_dsq_ff <= dab_in * dab_in;
         s1_ssq_ff <= sab_in * sab_in;

         s2_x_ff   <= s1_x_ff;
         s2_z_ff   <= s1_z_ff;
         s2_r2_ff  <= {1'b0, s1_xsq_ff} + {1'b0, s1_zsq_ff};
         s2_ssq_ff <= s1_ssq_ff;
         s2_asq_ff <= s1_asq_ff;
         s2_bsq_ff <= s1_bsq_ff;
         s2_dsq_ff <= s1_dsq_ff;

         s3_r2_ff   <= s2_r2_ff;
         s3_bsq_ff  <= s2_bsq_ff;
         s3_side_ff <= s3_side_in;

         s4_prod_ff <= {prod_in, 2'b00};
         s4_nsq_ff  <= s3_side_ff.nmag * s3_side_ff.nmag;
         s4_side_ff <= s3_side_ff;

         sq_v_ff[0] <= s4_prod_ff - s4_nsq_ff;
         sq_r_ff[0] <= 64'd0;
         side_ff[0] <= s4_side_ff;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            sq_v_ff[k+1] <= sq_v_in[k];
            sq_r_ff[k+1] <= sq_r_in[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // angle units
   cordic_in_type inner_vec, base_vec;
   logic signed [31:0] inner_ang, base_ang;
   side_type last_side;

   assign last_side      = side_ff[SQRT_STEPS];
   assign inner_vec.xneg = last_side.nneg;
   assign inner_vec.yneg = 1'b0;
   assign inner_vec.xmag = last_side.nmag;
   assign inner_vec.ymag = sq_r_ff[SQRT_STEPS][31:0];
   assign base_vec.xneg  = last_side.xneg;
   assign base_vec.yneg  = last_side.zneg;
   assign base_vec.xmag  = {16'b0, last_side.xmag};
   assign base_vec.ymag  = {16'b0, last_side.zmag};

   tlik_cordic u_inner (.clock(clock), .en(en), .vec(inner_vec), .angle(inner_ang));
   tlik_cordic u_base  (.clock(clock), .en(en), .vec(base_vec),  .angle(base_ang));

   logic rch_ff [CORDIC_LATENCY];

   always_ff @(posedge clock) begin
      if (en) begin
         rch_ff[0] <= last_side.reach;
         for (int k = 1; k < CORDIC_LATENCY; k++) begin
            rch_ff[k] <= rch_ff[k-1];
         end
      end
   end

   function automatic logic signed [15:0] to_out(input logic signed [31:0] v);
      logic signed [32:0] r;
      r = (33'(v) + 33'sd2048) >>> 12;
      if (r > 33'sd32767) begin
         return 16'sh7fff;
      end else if (r < -33'sd32768) begin
         return 16'sh8000;
      end
      return r[15:0];
   endfunction

   logic signed [15:0] first_ff, second_ff;
   logic reach_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         reach_ff  <= rch_ff[CORDIC_LATENCY-1];
         first_ff  <= rch_ff[CORDIC_LATENCY-1] ? to_out(base_ang + inner_ang) : 16'sd0;
         second_ff <= rch_ff[CORDIC_LATENCY-1] ? to_out(base_ang - inner_ang) : 16'sd0;
      end
   end

   assign rsp_chan.valid        = vld_ff[NSTAGES-1];
   assign rsp_chan.first_angle  = first_ff;
   assign rsp_chan.second_angle = second_ff;
   assign rsp_chan.reachable    = reach_ff;

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.reachable |->
         rsp_chan.first_angle == 16'sd0 && rsp_chan.second_angle == 16'sd0)
      else $error("unreachable result with nonzero angles");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[0])
      else $error("accepted transaction not in first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

endmodule
`default_nettype wire
